// ===== hdl/aging_linear_probe_name_table_core_macros.svh =====
// assertion macros shared by the name table rtl
`ifndef AGING_LINEAR_PROBE_NAME_TABLE_CORE_MACROS_SVH
`define AGING_LINEAR_PROBE_NAME_TABLE_CORE_MACROS_SVH

// condition that holds at every clock edge out of reset
`define ALPNT_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error(msg);

// consequent that holds in the same cycle as its antecedent
`define ALPNT_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/alpnt_pkg.sv =====
// types, codes and helpers of the aging name table
package alpnt_pkg;

	localparam int KEY_W      = 22;
	localparam int AGE_W      = 8;
	localparam int HEAD_W     = 64;
	localparam int TAIL_W     = 24;
	localparam int NAME_W     = HEAD_W + TAIL_W;
	localparam int NAME_BYTES = NAME_W / 8;
	// key reduction takes a reciprocal multiply, a back multiply and a correction
	localparam int HASH_STEPS = 3;
	localparam int HB_W       = $clog2(HASH_STEPS);
	localparam int OCC_W      = 9;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [AGE_W-1:0] MAX_AGE_RST = 8'd10;
	localparam logic             REG_MAX_AGE = 1'b0;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_SWEEP  = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// lookup key width codes, anything else acts as ten bits
	localparam logic [1:0] KW_FULL = 2'd0;
	localparam logic [1:0] KW_12   = 2'd1;
	localparam logic [1:0] KW_10   = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_SWEEP
	} state_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [1:0]        key_width;
		logic [KEY_W-1:0]  key_hash;
		logic [HEAD_W-1:0] name_head;
		logic [TAIL_W-1:0] name_tail;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [HEAD_W-1:0] found_head;
		logic [TAIL_W-1:0] found_tail;
		logic [OCC_W-1:0]  occupied;
	} result_t;

	typedef struct packed {
		logic [HEAD_W-1:0] head;
		logic [TAIL_W-1:0] tail;
	} name_t;

	typedef struct packed {
		logic [AGE_W-1:0] age;
		logic [KEY_W-1:0] key;
		name_t            name;
	} entry_t;

	// zero every name byte from the first zero byte on
	function automatic name_t clean_name(input logic [HEAD_W-1:0] head,
		input logic [TAIL_W-1:0] tail);
		logic [NAME_W-1:0] full;
		logic              ended;
		name_t             r;
		full  = {head, tail};
		ended = 1'b0;
		for (int b = 0; b < NAME_BYTES; b++) begin
			if (ended) begin
				full[NAME_W-1-8*b -: 8] = 8'h00;
			end else if (full[NAME_W-1-8*b -: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
		r.head = full[NAME_W-1 -: HEAD_W];
		r.tail = full[TAIL_W-1:0];
		return r;
	endfunction

endpackage

// ===== hdl/alpnt_apb_regs.sv =====
// apb register file holding the eviction age
module alpnt_apb_regs
	import alpnt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [AGE_W-1:0]      max_age
);

	logic             reg_sel;
	logic             wr_en;
	logic [AGE_W-1:0] max_age_q;

	// word index sits above the byte offset
	assign reg_sel = (paddr[APB_ADDR_W-1] == REG_MAX_AGE);
	assign wr_en   = psel && penable && pwrite && reg_sel;
	assign pready  = 1'b1;

	// eviction age register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= MAX_AGE_RST;
		end else if (wr_en) begin
			max_age_q <= pwdata[AGE_W-1:0];
		end
	end

	// read back
	assign prdata  = reg_sel ? APB_DATA_W'(max_age_q) : '0;
	assign max_age = max_age_q;

endmodule

// ===== hdl/aging_linear_probe_name_table_core.sv =====
// top level of the aging name table: sequencer around one entry memory
// Open-addressed name table with linear probing. An item is taken when start is high and
// busy is low; done goes high for one cycle with its result on result, and cannot be
// held off. Insert and lookup first reduce key_hash modulo TABLE_ENTRIES by a reciprocal
// multiply, a back multiply and one correction step, then probe one entry per cycle
// through the registered-read entry memory, from 1 up to TABLE_ENTRIES entries, with
// done in the cycle after the last probe. An age sweep reads every entry, one a cycle,
// and writes back each occupied one with its age raised by one, or cleared once its age
// has reached max_age. An insert of an empty name and operation three answer in the
// cycle after acceptance. After reset the block clears every memory entry with busy
// high; register writes are taken meanwhile. A new item may be accepted in the same
// cycle as the previous result is shown.
`include "aging_linear_probe_name_table_core_macros.svh"

module aging_linear_probe_name_table_core
	import alpnt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  done,
	output result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W:0]   N_EXT    = (IDX_W + 1)'(TABLE_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(TABLE_ENTRIES);
	localparam logic [HB_W-1:0]  HB_LAST  = HB_W'(HASH_STEPS - 1);
	localparam logic [KEY_W-1:0] N_KEY    = KEY_W'(TABLE_ENTRIES);
	localparam logic [KEY_W-1:0] RECIP    = KEY_W'((64'd1 << KEY_W) / TABLE_ENTRIES);

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   idx_q, idx_next, rd_addr, rem_new;
	logic [2*KEY_W-1:0] prod;
	logic [KEY_W-1:0]   quo_s1, rem_est;
	logic [IDX_W:0]     rem_s2;
	logic [IDX_W-1:0]   probe_q;
	logic [HB_W-1:0]    hb_q;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               done_q;
	result_t            result_q;

	logic [1:0]       op_q, kw_q;
	logic [KEY_W-1:0] key_q;
	name_t            name_q, name_in;

	entry_t           mem [TABLE_ENTRIES];
	entry_t           rdata_q;
	logic             mem_we;
	entry_t           mem_wdata;

	logic             accept, to_probe;
	logic             ent_empty, ent_same, key_hit, last_probe;
	logic             probe_done, res_fire, cnt_inc, cnt_dec;
	logic [1:0]       res_status;
	name_t            res_name;
	logic [AGE_W-1:0] max_age;

	// configuration port
	alpnt_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.max_age (max_age)
	);

	// item intake
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && (state_q == ST_IDLE);
	assign name_in  = clean_name(item.name_head, item.name_tail);
	assign to_probe = ((item.operation == OP_INSERT) && (name_in.head[HEAD_W-1 -: 8] != 8'h00))
		|| (item.operation == OP_LOOKUP);

	// key reduction: quotient estimate low by at most one, then one correction
	assign prod     = (2*KEY_W)'(key_q) * (2*KEY_W)'(RECIP);
	assign rem_est  = key_q - quo_s1 * N_KEY;
	assign rem_new  = (rem_s2 >= N_EXT) ? IDX_W'(rem_s2 - N_EXT) : rem_s2[IDX_W-1:0];

	// probe index wrap
	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	// memory read address: first or next probe entry, or next sweep entry
	always_comb begin
		unique case (state_q)
			ST_HASH:  rd_addr = rem_new;
			ST_PROBE,
			ST_SWEEP: rd_addr = idx_next;
			default:  rd_addr = '0;
		endcase
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= mem_wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	// entry compare
	assign ent_empty  = (rdata_q.name.head[HEAD_W-1 -: 8] == 8'h00);
	assign ent_same   = (rdata_q.key == key_q) && (rdata_q.name == name_q);
	assign last_probe = (probe_q == LAST_IDX);

	always_comb begin
		priority if (kw_q == KW_FULL) begin
			key_hit = (rdata_q.key == key_q);
		end else if (kw_q == KW_12) begin
			key_hit = (rdata_q.key[KEY_W-1 -: 12] == key_q[11:0]);
		end else begin
			key_hit = (rdata_q.key[KEY_W-1 -: 10] == key_q[9:0]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (idx_q == LAST_IDX) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept && to_probe) begin
					state_d = ST_HASH;
				end else if (accept && (item.operation == OP_SWEEP)) begin
					state_d = ST_SWEEP;
				end
			end
			ST_HASH:  if (hb_q == '0) state_d = ST_PROBE;
			ST_PROBE: if (probe_done) state_d = ST_IDLE;
			ST_SWEEP: if (idx_q == LAST_IDX) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// datapath actions per state
	always_comb begin
		mem_we     = 1'b0;
		mem_wdata  = '0;
		probe_done = 1'b0;
		res_fire   = 1'b0;
		res_status = STAT_DONE;
		res_name   = '0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		unique case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_IDLE: begin
				// empty-name insert and no-op answer without hashing or probing
				res_fire = accept && !to_probe && (item.operation != OP_SWEEP);
			end
			ST_PROBE: begin
				if (op_q == OP_INSERT) begin
					priority if (ent_empty) begin
						mem_we     = 1'b1;
						mem_wdata  = '{age: '0, key: key_q, name: name_q};
						cnt_inc    = 1'b1;
						probe_done = 1'b1;
					end else if (ent_same) begin
						mem_we     = 1'b1;
						mem_wdata  = rdata_q;
						mem_wdata.age = '0;
						probe_done = 1'b1;
					end else if (last_probe) begin
						res_status = STAT_FULL;
						probe_done = 1'b1;
					end else begin
						// keep probing
						probe_done = 1'b0;
					end
				end else begin
					priority if (ent_empty) begin
						res_status = STAT_MISS;
						probe_done = 1'b1;
					end else if (key_hit) begin
						res_name   = rdata_q.name;
						probe_done = 1'b1;
					end else if (last_probe) begin
						res_status = STAT_MISS;
						probe_done = 1'b1;
					end else begin
						// keep probing
						probe_done = 1'b0;
					end
				end
				res_fire = probe_done;
			end
			ST_SWEEP: begin
				if (!ent_empty) begin
					mem_we = 1'b1;
					if (rdata_q.age >= max_age) begin
						cnt_dec = (count_q != '0);
					end else begin
						mem_wdata     = rdata_q;
						mem_wdata.age = rdata_q.age + 1'b1;
					end
				end
				res_fire = (idx_q == LAST_IDX);
			end
			default: ;
		endcase
	end

	assign count_d = count_q + CNT_W'(cnt_inc) - CNT_W'(cnt_dec);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
			probe_q <= '0;
			hb_q    <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= res_fire;
			unique case (state_q)
				ST_CLEAR: idx_q <= idx_next;
				ST_IDLE: begin
					idx_q   <= '0;
					probe_q <= '0;
					hb_q    <= HB_LAST;
				end
				ST_HASH: begin
					idx_q <= rem_new;
					hb_q  <= hb_q - 1'b1;
				end
				ST_PROBE: begin
					idx_q   <= idx_next;
					probe_q <= probe_q + 1'b1;
				end
				ST_SWEEP: idx_q <= idx_next;
				default: ;
			endcase
		end
	end

	// item payload, key reduction pipeline and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= item.operation;
			kw_q   <= item.key_width;
			key_q  <= item.key_hash;
			name_q <= name_in;
		end
		quo_s1 <= prod[2*KEY_W-1 -: KEY_W];
		rem_s2 <= rem_est[IDX_W:0];
		if (res_fire) begin
			result_q.status     <= res_status;
			result_q.found_head <= res_name.head;
			result_q.found_tail <= res_name.tail;
			result_q.occupied   <= OCC_W'(count_d);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// checks
	`ALPNT_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_MAX,
		"entry count above table size")
	`ALPNT_ASSERT_IMPLY(a_done_source, clk, arst_n, done_q,
		$past(state_q == ST_PROBE || state_q == ST_SWEEP || (start && !busy)),
		"result without a finished item")
	`ALPNT_ASSERT_IMPLY(a_hit_status, clk, arst_n,
		done_q && (result_q.found_head != '0), result_q.status == STAT_DONE,
		"name returned with a miss status")
	`ALPNT_ASSERT_IMPLY(a_write_state, clk, arst_n, mem_we,
		state_q == ST_CLEAR || state_q == ST_PROBE || state_q == ST_SWEEP,
		"memory written outside clear, probe or sweep")

endmodule
